/* hdl/spq_pkg.sv */
// ----------------------------------------------------------------------------
// spq_pkg: shared types and codes of the sorted priority queue
// Word layouts of both channels, the entry held by one cell, operation and
// status codes.
// ----------------------------------------------------------------------------
`default_nettype none

package spq_pkg;

  localparam int CNT_W = 5;

  localparam logic [1:0] OP_ENQUEUE = 2'd0;
  localparam logic [1:0] OP_DEQUEUE = 2'd1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  localparam logic [CNT_W-1:0] CAP_RESET = 5'd16;

  typedef struct packed {
    logic [1:0]         opcode;
    logic signed [31:0] item_value;
    logic [15:0]        item_priority;
  } in_word_t;

  typedef struct packed {
    logic [1:0]         status_code;
    logic signed [31:0] head_value;
    logic [15:0]        head_priority;
    logic [CNT_W-1:0]   entry_count;
    logic               empty_flag;
    logic               full_flag;
  } out_word_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic [15:0]        prio;
  } entry_t;

  // Shift control broadcast to every cell.
  typedef struct packed {
    logic enq;
    logic deq;
  } cell_ctl_t;

endpackage

`default_nettype wire

/* hdl/sorted_priority_queue_unit.sv */
// ----------------------------------------------------------------------------
// sorted_priority_queue_unit: bounded priority queue on a sorted cell chain
// Entries sit in a row of cells, highest priority at cell 0. An enqueue
// opens a gap at the insert point and shifts the tail one cell right; a
// dequeue hands cell 0 out and shifts the whole row one cell left.
//
//   channel | ports                           | direction | word type
//   --------+---------------------------------+-----------+-----------
//   input   | in_valid / in_ready / in_word   | in        | in_word_t
//   result  | out_valid / out_ready / out_word| out       | out_word_t
//   config  | cfg_we / cfg_wdata              | in        | capacity
//
// One word a cycle: every cell compares and shifts in the same cycle the
// word is accepted, and the result is loaded into the output register on
// that same clock edge. The input stalls only while a result sits unread in that register.
// Reset (rst_n low, synchronous) empties the queue and sets the capacity to
// 16; cell contents are not cleared, since only held cells are ever read.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_priority_queue_unit
  import spq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire in_word_t         in_word,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output out_word_t             out_word,
  input  wire logic             cfg_we,
  input  wire logic [CNT_W-1:0] cfg_wdata
);

  // Saturate the capacity to the chain length (a 5-bit capacity never
  // reaches past 31, so deeper chains cap there).
  localparam int unsigned DepthSat = (QUEUE_DEPTH > 31) ? 31 : QUEUE_DEPTH;
  localparam logic [CNT_W-1:0] DEPTH_CODE = CNT_W'(DepthSat);

  logic [CNT_W-1:0] cap_r;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic [CNT_W-1:0] eff_cap;
  logic             out_valid_r;
  out_word_t        out_word_r;
  out_word_t        result;
  logic             accept;
  cell_ctl_t        ctl;
  entry_t           new_entry;
  entry_t           cell_q  [QUEUE_DEPTH];
  logic             ge      [QUEUE_DEPTH];

  assign eff_cap   = (cap_r > DEPTH_CODE) ? DEPTH_CODE : cap_r;
  assign in_ready  = !out_valid_r || out_ready;
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  assign new_entry.value = in_word.item_value;
  assign new_entry.prio  = in_word.item_priority;

  // Decide the operation and build the result word at accept time.
  always_comb begin
    ctl                  = '0;
    count_nxt            = count_r;
    result.status_code   = ST_OK;
    result.head_value    = '0;
    result.head_priority = '0;
    case (in_word.opcode)
      OP_ENQUEUE: begin
        if (count_r >= eff_cap) begin
          result.status_code = ST_FULL;
        end else begin
          ctl.enq   = accept;
          count_nxt = count_r + CNT_W'(1);
        end
      end
      OP_DEQUEUE: begin
        if (count_r == '0) begin
          result.status_code = ST_EMPTY;
        end else begin
          ctl.deq              = accept;
          count_nxt            = count_r - CNT_W'(1);
          result.head_value    = cell_q[0].value;
          result.head_priority = cell_q[0].prio;
        end
      end
      default: begin
        // status query: report only
        ctl = '0;
      end
    endcase
    result.entry_count = count_nxt;
    result.empty_flag  = (count_nxt == '0);
    result.full_flag   = (count_nxt >= eff_cap);
  end

  // Chain of cells: each sees its left neighbor's compare and both
  // neighbors' entries. Cell 0 always takes the new entry when it moves on an enqueue.
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_head
      spq_cell #(.IDX(i)) u_cell (
        .clk        (clk),
        .ctl        (ctl),
        .new_entry  (new_entry),
        .count      (count_r),
        .left_entry (new_entry),
        .left_ge    (1'b1),
        .right_entry(cell_q[1]),
        .entry      (cell_q[i]),
        .ge         (ge[i])
      );
    end else if (i == QUEUE_DEPTH - 1) begin : g_tail
      // Last cell holds its own entry on a dequeue.
      spq_cell #(.IDX(i)) u_cell (
        .clk        (clk),
        .ctl        (ctl),
        .new_entry  (new_entry),
        .count      (count_r),
        .left_entry (cell_q[i-1]),
        .left_ge    (ge[i-1]),
        .right_entry(cell_q[i]),
        .entry      (cell_q[i]),
        .ge         (ge[i])
      );
    end else begin : g_mid
      spq_cell #(.IDX(i)) u_cell (
        .clk        (clk),
        .ctl        (ctl),
        .new_entry  (new_entry),
        .count      (count_r),
        .left_entry (cell_q[i-1]),
        .left_ge    (ge[i-1]),
        .right_entry(cell_q[i+1]),
        .entry      (cell_q[i]),
        .ge         (ge[i])
      );
    end
  end

  // Control registers: capacity, occupancy, result valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= CAP_RESET;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
      if (accept) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result register: load on accept, hold while stalled.
  always_ff @(posedge clk) begin
    if (accept) begin
      out_word_r <= result;
    end
  end

endmodule

`default_nettype wire

/* hdl/spq_cell.sv */
// ----------------------------------------------------------------------------
// spq_cell: one slot of the sorted chain
// Holds one entry; on enqueue keeps, takes the new entry or takes the left
// neighbor; on dequeue takes the right neighbor.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_cell
  import spq_pkg::*;
#(
  parameter int IDX = 0
) (
  input  wire logic       clk,
  input  wire cell_ctl_t  ctl,
  input  wire entry_t     new_entry,
  input  wire logic [CNT_W-1:0] count,
  input  wire entry_t     left_entry,
  input  wire logic       left_ge,
  input  wire entry_t     right_entry,
  output entry_t          entry,
  output logic            ge
);

  // Occupancy never exceeds 31, so slots at or past 31 never read as held.
  localparam int unsigned IdxSat = (IDX > 31) ? 31 : IDX;
  localparam logic [CNT_W-1:0] IdxCode = CNT_W'(IdxSat);

  entry_t data_r;
  entry_t data_nxt;
  logic   occ;

  assign occ   = (count > IdxCode);
  // Held entries at or above the new priority stay ahead of it.
  assign ge    = occ && (data_r.prio >= new_entry.prio);
  assign entry = data_r;

  always_comb begin
    data_nxt = data_r;
    if (ctl.enq && !ge) begin
      data_nxt = left_ge ? new_entry : left_entry;
    end else if (ctl.deq) begin
      data_nxt = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

endmodule

`default_nettype wire

/* hdl/spq_checker.sv */
// ----------------------------------------------------------------------------
// spq_checker: port-level checks of the sorted priority queue
// Watches the result channel and the input stall and flags inconsistent
// result words.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_checker
  import spq_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_ready,
  input wire logic      out_valid,
  input wire logic      out_ready,
  input wire out_word_t out_word
);

  // Hold a stalled result word.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_word))
    else $error("result word changed while stalled");

  // Stall the input only behind an unread result.
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled with no result pending");

  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_word.empty_flag == (out_word.entry_count == '0))
    else $error("empty flag disagrees with count");

  // A refused dequeue leaves an empty queue and no head.
  a_empty_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.status_code == ST_EMPTY |->
      out_word.entry_count == '0 && out_word.head_value == '0 &&
      out_word.head_priority == '0)
    else $error("empty status with data or entries");

  // A refused enqueue reports a full queue.
  a_full_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.status_code == ST_FULL |-> out_word.full_flag)
    else $error("full status without full flag");

endmodule

bind sorted_priority_queue_unit spq_checker u_spq_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_ready (in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_word (out_word)
);

`default_nettype wire
